// File: rtl/keyed_entry_table_upsert_remove_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the keyed entry table
// Shared property forms, clocked on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef KEYED_ENTRY_TABLE_UPSERT_REMOVE_DEFINES_SVH
`define KEYED_ENTRY_TABLE_UPSERT_REMOVE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KETUR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KETUR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/ketur_pkg.sv
// ---------------------------------------------------------------------------
// Keyed entry table package
// Field widths, record and beat types, operation and status codes.
// ---------------------------------------------------------------------------
package ketur_pkg;

  localparam int KEY_W         = 16;
  localparam int FIELD_W       = 16;
  localparam int ENTRY_CNT_W   = 5;
  localparam int IN_DATA_W     = 80;
  localparam int OUT_DATA_W    = 8;
  localparam int DEF_TABLE_DEPTH = 16;

  typedef enum logic {
    MODE_UPSERT = 1'b0,
    MODE_REMOVE = 1'b1
  } mode_t;

  typedef enum logic [2:0] {
    ST_UPDATED   = 3'd0,
    ST_INSERTED  = 3'd1,
    ST_FULL      = 3'd2,
    ST_REMOVED   = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] hit_points;
    logic [FIELD_W-1:0]        heading;
    logic [FIELD_W-1:0]        pos_y;
    logic [FIELD_W-1:0]        pos_x;
  } rec_t;

  typedef struct packed {
    mode_t            mode;
    logic [KEY_W-1:0] key;
    rec_t             rec;
  } req_t;

  typedef struct packed {
    status_t                status;
    logic [ENTRY_CNT_W-1:0] entry_count;
  } resp_t;

endpackage

// File: rtl/keyed_entry_table_upsert_remove.sv
// ---------------------------------------------------------------------------
// Keyed entry table with upsert and swap-remove
// Each input beat scans the stored keys, then acts (a remove hit adds a move
// step) and registers a result beat; no new input beat is taken until that
// result beat has been registered, so items are handled one at a time.
// Synchronous active-low reset empties the table at once; no clearing pass.
// ---------------------------------------------------------------------------
module keyed_entry_table_upsert_remove #(
  parameter int TABLE_DEPTH = ketur_pkg::DEF_TABLE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // key, pos_x, pos_y, heading, hit_points
  input  logic [ketur_pkg::IN_DATA_W-1:0] in_tdata,
  // mode
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // status, entry_count
  output logic [ketur_pkg::OUT_DATA_W-1:0] out_tdata
);
  import ketur_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  req_t             req;
  resp_t            resp;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic             mem_re;
  logic [IDX_W-1:0] mem_raddr;
  logic [KEY_W-1:0] key_wdata;
  logic [KEY_W-1:0] key_rdata;
  rec_t             rec_wdata;
  rec_t             rec_rdata;

  assign req.mode           = mode_t'(in_tuser);
  assign req.key            = in_tdata[15:0];
  assign req.rec.pos_x      = in_tdata[31:16];
  assign req.rec.pos_y      = in_tdata[47:32];
  assign req.rec.heading    = in_tdata[63:48];
  assign req.rec.hit_points = in_tdata[79:64];

  assign out_tdata = {resp.entry_count, resp.status};

  ketur_ctrl #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .IDX_W(IDX_W)
  ) u_ctrl (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_tvalid),
    .in_ready(in_tready),
    .req(req),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .resp(resp),
    .mem_we(mem_we),
    .mem_waddr(mem_waddr),
    .mem_re(mem_re),
    .mem_raddr(mem_raddr),
    .key_wdata(key_wdata),
    .rec_wdata(rec_wdata),
    .key_rdata(key_rdata),
    .rec_rdata(rec_rdata)
  );

  ketur_ram #(
    .DEPTH(TABLE_DEPTH),
    .WIDTH(KEY_W),
    .ADDR_W(IDX_W)
  ) u_key_ram (
    .clk(clk),
    .we(mem_we),
    .waddr(mem_waddr),
    .wdata(key_wdata),
    .re(mem_re),
    .raddr(mem_raddr),
    .rdata(key_rdata)
  );

  ketur_ram #(
    .DEPTH(TABLE_DEPTH),
    .WIDTH($bits(rec_t)),
    .ADDR_W(IDX_W)
  ) u_rec_ram (
    .clk(clk),
    .we(mem_we),
    .waddr(mem_waddr),
    .wdata(rec_wdata),
    .re(mem_re),
    .raddr(mem_raddr),
    .rdata(rec_rdata)
  );

endmodule

// File: rtl/ketur_ram.sv
// ---------------------------------------------------------------------------
// Keyed entry table storage memory
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module ketur_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/ketur_ctrl.sv
// ---------------------------------------------------------------------------
// Keyed entry table sequencer
// Scans stored keys, then updates, appends or swap-removes at most one record.
// ---------------------------------------------------------------------------
module ketur_ctrl #(
  parameter int TABLE_DEPTH = 16,
  parameter int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  ketur_pkg::req_t           req,
  output logic                      out_valid,
  input  logic                      out_ready,
  output ketur_pkg::resp_t          resp,
  output logic                      mem_we,
  output logic [IDX_W-1:0]          mem_waddr,
  output logic                      mem_re,
  output logic [IDX_W-1:0]          mem_raddr,
  output logic [ketur_pkg::KEY_W-1:0] key_wdata,
  output ketur_pkg::rec_t           rec_wdata,
  input  logic [ketur_pkg::KEY_W-1:0] key_rdata,
  input  ketur_pkg::rec_t           rec_rdata
);
  import ketur_pkg::*;

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] ONE     = CNT_W'(1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_ACT,
    S_MOVE,
    S_RESP
  } state_t;

  state_t           state_r;
  mode_t            mode_r;
  logic [KEY_W-1:0] key_r;
  rec_t             rec_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] rd_idx_r;
  logic [IDX_W-1:0] cmp_idx_r;
  logic             pend_r;
  logic             hit_r;
  status_t          status_r;
  logic             out_valid_r;
  resp_t            resp_r;

  logic             match;
  logic             scan_more;
  logic             has_room;
  logic [CNT_W-1:0] last_idx;
  logic [31:0]      count_wide;

  assign match      = pend_r && (key_rdata == key_r);
  assign scan_more  = rd_idx_r < count_r;
  assign has_room   = count_r < DEPTH_C;
  assign last_idx   = count_r - ONE;
  assign count_wide = 32'(count_r);

  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = rd_idx_r[IDX_W-1:0];
    mem_we    = 1'b0;
    mem_waddr = cmp_idx_r;
    key_wdata = key_r;
    rec_wdata = rec_r;
    unique case (state_r)
      S_SEARCH: begin
        mem_re = !match && scan_more;
      end
      S_ACT: begin
        if (mode_r == MODE_UPSERT) begin
          if (hit_r) begin
            mem_we = 1'b1;
          end else if (has_room) begin
            mem_we    = 1'b1;
            mem_waddr = count_r[IDX_W-1:0];
          end
        end else if (hit_r) begin
          mem_re    = 1'b1;
          mem_raddr = last_idx[IDX_W-1:0];
        end
      end
      S_MOVE: begin
        mem_we    = 1'b1;
        key_wdata = key_rdata;
        rec_wdata = rec_rdata;
      end
      S_IDLE, S_RESP: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      pend_r      <= 1'b0;
      hit_r       <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && (state_r != S_RESP)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            mode_r   <= req.mode;
            key_r    <= req.key;
            rec_r    <= req.rec;
            rd_idx_r <= '0;
            pend_r   <= 1'b0;
            state_r  <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (match) begin
            hit_r   <= 1'b1;
            pend_r  <= 1'b0;
            state_r <= S_ACT;
          end else if (scan_more) begin
            pend_r    <= 1'b1;
            cmp_idx_r <= rd_idx_r[IDX_W-1:0];
            rd_idx_r  <= rd_idx_r + ONE;
          end else begin
            hit_r   <= 1'b0;
            pend_r  <= 1'b0;
            state_r <= S_ACT;
          end
        end
        S_ACT: begin
          if (mode_r == MODE_UPSERT) begin
            state_r <= S_RESP;
            if (hit_r) begin
              status_r <= ST_UPDATED;
            end else if (has_room) begin
              status_r <= ST_INSERTED;
              count_r  <= count_r + ONE;
            end else begin
              status_r <= ST_FULL;
            end
          end else if (hit_r) begin
            state_r <= S_MOVE;
          end else begin
            status_r <= ST_NOT_FOUND;
            state_r  <= S_RESP;
          end
        end
        S_MOVE: begin
          count_r  <= last_idx;
          status_r <= ST_REMOVED;
          state_r  <= S_RESP;
        end
        S_RESP: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r        <= 1'b1;
            resp_r.status      <= status_r;
            resp_r.entry_count <= count_wide[ENTRY_CNT_W-1:0];
            state_r            <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign resp      = resp_r;

endmodule

// File: rtl/ketur_checker.sv
// ---------------------------------------------------------------------------
// Keyed entry table port checker
// Watches the stream ports of the top level over time.
// ---------------------------------------------------------------------------
`include "keyed_entry_table_upsert_remove_defines.svh"

module ketur_checker #(
  parameter int TABLE_DEPTH = ketur_pkg::DEF_TABLE_DEPTH
) (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [ketur_pkg::OUT_DATA_W-1:0] out_tdata
);
  import ketur_pkg::*;

  localparam logic [31:0] DEPTH_WIDE = 32'(TABLE_DEPTH);

  logic [2:0] out_status;
  logic [4:0] out_count;

  assign out_status = out_tdata[2:0];
  assign out_count  = out_tdata[7:3];

  `KETUR_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result beat changed while stalled")
  `KETUR_ASSERT_NEXT(a_one_at_a_time, in_tvalid && in_tready, !in_tready, "input taken while an item is in progress")
  `KETUR_ASSERT_SAME(a_full_count, out_tvalid && (out_status == ST_FULL), out_count == DEPTH_WIDE[4:0], "full status with a table that is not full")

endmodule

bind keyed_entry_table_upsert_remove ketur_checker #(
  .TABLE_DEPTH(TABLE_DEPTH)
) u_ketur_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_tvalid(in_tvalid),
  .in_tready(in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata(out_tdata)
);

// File: bench/keyed_entry_table_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Keyed entry table result checker
// Watches the input and result streams of the table. It keeps its own
// mirror of the table, works out the status and count for every accepted
// input beat, and compares each result beat with the oldest one waiting.
// ---------------------------------------------------------------------------
module keyed_entry_table_checker #(
  parameter int TABLE_DEPTH = ketur_pkg::DEF_TABLE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [ketur_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                             in_tuser,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [ketur_pkg::OUT_DATA_W-1:0] out_tdata,
  output int                               err_count,
  output int                               pending,
  output int                               checked_count
);
  import ketur_pkg::*;

  logic [KEY_W-1:0] key_mirror [TABLE_DEPTH];
  rec_t             rec_mirror [TABLE_DEPTH];
  int               fill = 0;
  resp_t            outcome_q [$];

  initial begin
    err_count     = 0;
    pending       = 0;
    checked_count = 0;
  end

  function automatic resp_t apply_request(mode_t m, logic [KEY_W-1:0] k, rec_t r);
    int    hit;
    resp_t res;
    hit = -1;
    for (int i = 0; i < fill; i++) begin
      if (hit < 0 && key_mirror[i] == k) begin
        hit = i;
      end
    end
    if (m == MODE_UPSERT) begin
      if (hit >= 0) begin
        rec_mirror[hit] = r;
        res.status = ST_UPDATED;
      end else if (fill < TABLE_DEPTH) begin
        key_mirror[fill] = k;
        rec_mirror[fill] = r;
        fill++;
        res.status = ST_INSERTED;
      end else begin
        res.status = ST_FULL;
      end
    end else begin
      if (hit >= 0) begin
        key_mirror[hit] = key_mirror[fill-1];
        rec_mirror[hit] = rec_mirror[fill-1];
        fill--;
        res.status = ST_REMOVED;
      end else begin
        res.status = ST_NOT_FOUND;
      end
    end
    res.entry_count = ENTRY_CNT_W'(fill);
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    err_count++;
  endtask

  always @(posedge clk) begin : watch
    resp_t seen;
    resp_t want;
    rec_t  rec;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        seen.status      = status_t'(out_tdata[2:0]);
        seen.entry_count = out_tdata[7:3];
        if (outcome_q.size() == 0) begin
          report_mismatch("unexpected result beat, status", seen.status, 0);
        end else begin
          want = outcome_q.pop_front();
          if (seen.status != want.status) begin
            report_mismatch("status", seen.status, want.status);
          end
          if (seen.entry_count != want.entry_count) begin
            report_mismatch("entry_count", seen.entry_count, want.entry_count);
          end
          checked_count++;
        end
      end
      if (in_tvalid && in_tready) begin
        rec.pos_x      = in_tdata[31:16];
        rec.pos_y      = in_tdata[47:32];
        rec.heading    = in_tdata[63:48];
        rec.hit_points = in_tdata[79:64];
        outcome_q.push_back(apply_request(mode_t'(in_tuser), in_tdata[15:0], rec));
      end
    end
    pending <= outcome_q.size();
  end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Keyed entry table testbench
// Drives upsert and remove beats into the table: a directed opening that
// fills, overflows and empties parts of it, then random phases over small
// key pools with random gaps on both streams, a long output hold-off and
// drained pauses. A separate checker predicts and compares every result.
// ---------------------------------------------------------------------------
module tb_top;
  import ketur_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 150;
  localparam int PHASES      = 8;
  localparam int PHASE_BEATS = 85;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  in_tuser   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  int err_count;
  int pending;
  int checked_count;

  bit               hold_off_req = 1'b0;
  bit               no_idle      = 1'b0;
  int               upserts_sent = 0;
  int               removes_sent = 0;
  logic [KEY_W-1:0] key_pool [20];
  rec_t             rec;
  mode_t            mode;
  int               upsert_pct;
  int               pool_size;

  keyed_entry_table_upsert_remove DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  keyed_entry_table_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .err_count    (err_count),
    .pending      (pending),
    .checked_count(checked_count)
  );

  initial begin
    forever begin
      #5 clk = ~clk;
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("DONE: errors detected");
    $finish;
  end

  function automatic rec_t random_rec();
    rec_t r;
    r.pos_x      = 16'($urandom);
    r.pos_y      = 16'($urandom);
    r.heading    = 16'($urandom_range(0, 51471));
    r.hit_points = 16'($urandom);
    return r;
  endfunction

  // Fields are packed key, pos_x, pos_y, heading, hit_points from bit 0 up.
  task automatic send_beat(mode_t m, logic [KEY_W-1:0] k, rec_t r);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= m;
    in_tdata  <= {r.hit_points, r.heading, r.pos_y, r.pos_x, k};
    if (m == MODE_UPSERT) begin
      upserts_sent++;
    end else begin
      removes_sent++;
    end
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Result side: a fresh wait before every beat, and one long hold-off on request.
  initial begin : result_side
    int gap;
    @(posedge rst_n);
    forever begin
      if (hold_off_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end
      gap = no_idle ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  initial begin : stimulus
    rec_t ones;
    key_pool[0] = 16'h0000;
    key_pool[1] = 16'hFFFF;
    for (int i = 2; i < 20; i++) begin
      key_pool[i] = 16'($urandom);
    end
    ones.pos_x      = 16'hFFFF;
    ones.pos_y      = 16'hFFFF;
    ones.heading    = 16'd51471;
    ones.hit_points = -16'sd32768;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_beat(MODE_REMOVE, 16'h0000, random_rec());
    send_beat(MODE_UPSERT, 16'h0000, '0);
    send_beat(MODE_UPSERT, 16'hFFFF, ones);
    rec = '0;
    rec.hit_points = 16'sd32767;
    send_beat(MODE_UPSERT, 16'h0000, rec);
    send_beat(MODE_REMOVE, 16'hFFFF, ones);
    for (int i = 1; i < 16; i++) begin
      send_beat(MODE_UPSERT, 16'(i * 16'h1111), random_rec());
    end
    send_beat(MODE_UPSERT, 16'h0F0F, random_rec());
    send_beat(MODE_UPSERT, 16'h3333, ones);
    send_beat(MODE_REMOVE, 16'h5555, random_rec());
    send_beat(MODE_REMOVE, 16'h1234, random_rec());
    wait_drained();

    for (int ph = 0; ph < PHASES; ph++) begin
      upsert_pct = (ph % 2 == 0) ? 70 : 35;
      pool_size  = (ph < 4) ? 20 : 6;
      no_idle    = (ph == 5);
      if (ph == 2) begin
        hold_off_req = 1'b1;
      end
      for (int n = 0; n < PHASE_BEATS; n++) begin
        mode = ($urandom_range(0, 99) < upsert_pct) ? MODE_UPSERT : MODE_REMOVE;
        if ($urandom_range(0, 99) < 88) begin
          send_beat(mode, key_pool[$urandom_range(0, pool_size - 1)], random_rec());
        end else begin
          send_beat(mode, 16'($urandom), random_rec());
        end
      end
      wait_drained();
    end

    no_idle = 1'b0;
    repeat (30) @(posedge clk);
    $display("Covered %0d upserts and %0d removes over a directed fill and %0d random phases,",
             upserts_sent, removes_sent, PHASES);
    $display("with a long output hold-off and drained pauses; %0d result beats checked.",
             checked_count);
    if (err_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
